[design/ptwa_pkg.sv]
// Shared types, constants and helpers for the peer table with aging.
// Used by ptwa_ctrl, ptwa_dp and peer_table_with_aging_unit.
`timescale 1ns / 1ps
package ptwa_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [6:0]  MIN_ANNOUNCE_BYTES = 7'd44;
    localparam logic [31:0] EXPIRY_RESET_MS    = 32'd8000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ANNOUNCING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_SESSION_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_LIMIT_MS = 2'd3;

    typedef enum logic [1:0] {
        OP_ANNOUNCE = 2'd0,
        OP_EXPIRE   = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_SHORT     = 4'd0,
        ST_BAD_MAGIC = 4'd1,
        ST_OWN       = 4'd2,
        ST_UPDATED   = 4'd3,
        ST_INSERTED  = 4'd4,
        ST_REPLACED  = 4'd5,
        ST_DROPPED   = 4'd6,
        ST_READ_OK   = 4'd7,
        ST_BAD_INDEX = 4'd8,
        ST_DONE      = 4'd9
    } status_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] now_ms;
        logic [6:0]  packet_length;
        logic [31:0] announce_magic;
        logic [31:0] announce_session;
        logic [15:0] announce_port;
        logic [7:0]  announce_players;
        logic [7:0]  announce_capacity;
        logic [31:0] sender_addr;
        logic [7:0]  entry_index;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot_used;
        logic        entry_active;
        logic [31:0] entry_session;
        logic [15:0] entry_port;
        logic [7:0]  entry_players;
        logic [7:0]  entry_capacity;
        logic [31:0] entry_addr;
        logic [31:0] entry_last_seen;
        logic [3:0]  active_count;
        logic [3:0]  span_used;
    } result_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;     // capture input transaction
        logic lookup;   // match / free / oldest search, register decision
        logic commit;   // update table, load result register
    } cmd_t;

    function automatic logic [2:0] fit_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[2:0];
    endfunction

    function automatic logic [3:0] fit_cnt(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[3:0];
    endfunction

endpackage

[design/ptwa_ctrl.sv]
// Controller for the peer table: idle / lookup / commit sequencing and result valid.
// Depends on ptwa_pkg (cmd_t).
`timescale 1ns / 1ps
module ptwa_ctrl
    import ptwa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit_go;

    // commit only when the result register is free or drains this cycle
    assign commit_go = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || commit_go;

    assign cmd.load   = in_valid && in_ready;
    assign cmd.lookup = (state_reg == S_LOOKUP);
    assign cmd.commit = commit_go;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                    state_next = cmd.load ? S_LOOKUP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/ptwa_dp.sv]
// Datapath for the peer table: config registers, entry registers, lookup logic,
// commit/update logic and result register. Depends on ptwa_pkg.
`timescale 1ns / 1ps
module ptwa_dp
    import ptwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  item_t                 item_in,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output result_t               result
);

    // configuration
    logic        self_announcing_reg;
    logic [31:0] self_session_id_reg;
    logic [31:0] magic_value_reg;
    logic [31:0] expiry_limit_ms_reg;

    // captured transaction
    item_t item_reg;

    // table
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0] key_reg      [TABLE_ENTRIES];
    logic [31:0] key_next     [TABLE_ENTRIES];
    logic [15:0] port_reg     [TABLE_ENTRIES];
    logic [15:0] port_next    [TABLE_ENTRIES];
    logic [7:0]  players_reg  [TABLE_ENTRIES];
    logic [7:0]  players_next [TABLE_ENTRIES];
    logic [7:0]  capacity_reg [TABLE_ENTRIES];
    logic [7:0]  capacity_next[TABLE_ENTRIES];
    logic [31:0] addr_reg     [TABLE_ENTRIES];
    logic [31:0] addr_next    [TABLE_ENTRIES];
    logic [31:0] seen_reg     [TABLE_ENTRIES];
    logic [31:0] seen_next    [TABLE_ENTRIES];
    logic [CNT_W-1:0] span_next;
    logic [CNT_W-1:0] count_next;

    // lookup stage
    logic [TABLE_ENTRIES-1:0] cand, old_win, expire_hit;
    logic [TABLE_ENTRIES-1:0] expire_mask_reg;
    logic             hit_found, free_found, old_found;
    logic [IDX_W-1:0] hit_idx, free_idx, old_idx;
    status_t          lk_status_reg, lk_status_next;
    logic [IDX_W-1:0] lk_slot_reg, lk_slot_next;

    // read
    logic             rd_in_range;
    logic [IDX_W-1:0] rd_idx;

    result_t result_reg, result_next;

    assign result = result_reg;

    // ---------------- lookup ----------------
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            cand[i]       = seen_reg[i] < item_reg.now_ms;
            expire_hit[i] = valid_reg[i] &&
                            ((item_reg.now_ms - seen_reg[i]) > expiry_limit_ms_reg);
        end
    end

    // oldest below now, ties go to the lower slot
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            old_win[i] = cand[i];
            for (int j = 0; j < TABLE_ENTRIES; j++)
            begin
                if (cand[j] && (j < i) && (seen_reg[j] <= seen_reg[i]))
                    old_win[i] = 1'b0;
                if (cand[j] && (j > i) && (seen_reg[j] < seen_reg[i]))
                    old_win[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        old_found  = 1'b0;
        old_idx    = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == item_reg.announce_session))
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (old_win[i])
            begin
                old_found = 1'b1;
                old_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        lk_slot_next = '0;
        if (item_reg.packet_length < MIN_ANNOUNCE_BYTES)
            lk_status_next = ST_SHORT;
        else if (item_reg.announce_magic != magic_value_reg)
            lk_status_next = ST_BAD_MAGIC;
        else if (self_announcing_reg && (self_session_id_reg == item_reg.announce_session))
            lk_status_next = ST_OWN;
        else if (hit_found)
        begin
            lk_status_next = ST_UPDATED;
            lk_slot_next   = hit_idx;
        end
        else if (free_found)
        begin
            lk_status_next = ST_INSERTED;
            lk_slot_next   = free_idx;
        end
        else if (old_found)
        begin
            lk_status_next = ST_REPLACED;
            lk_slot_next   = old_idx;
        end
        else
            lk_status_next = ST_DROPPED;
    end

    // ---------------- commit ----------------
    assign rd_in_range = {1'b0, item_reg.entry_index} < 9'(TABLE_ENTRIES);
    assign rd_idx      = item_reg.entry_index[IDX_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            key_next[i]      = key_reg[i];
            port_next[i]     = port_reg[i];
            players_next[i]  = players_reg[i];
            capacity_next[i] = capacity_reg[i];
            addr_next[i]     = addr_reg[i];
            seen_next[i]     = seen_reg[i];
        end
        result_next        = '0;
        result_next.status = ST_DONE;

        if (cmd.commit)
        begin
            case (item_reg.operation)
                OP_ANNOUNCE:
                begin
                    result_next.status = lk_status_reg;
                    if (lk_status_reg inside {ST_UPDATED, ST_INSERTED, ST_REPLACED})
                    begin
                        result_next.slot_used     = fit_slot(lk_slot_reg);
                        players_next[lk_slot_reg] = item_reg.announce_players;
                        seen_next[lk_slot_reg]    = item_reg.now_ms;
                    end
                    if (lk_status_reg inside {ST_INSERTED, ST_REPLACED})
                    begin
                        valid_next[lk_slot_reg]    = 1'b1;
                        key_next[lk_slot_reg]      = item_reg.announce_session;
                        port_next[lk_slot_reg]     = item_reg.announce_port;
                        capacity_next[lk_slot_reg] = item_reg.announce_capacity;
                        addr_next[lk_slot_reg]     = item_reg.sender_addr;
                    end
                end
                OP_EXPIRE:
                begin
                    valid_next = valid_reg & ~expire_mask_reg;
                end
                OP_READ:
                begin
                    if (rd_in_range)
                    begin
                        result_next.status          = ST_READ_OK;
                        result_next.slot_used       = fit_slot(rd_idx);
                        result_next.entry_active    = valid_reg[rd_idx];
                        result_next.entry_session   = key_reg[rd_idx];
                        result_next.entry_port      = port_reg[rd_idx];
                        result_next.entry_players   = players_reg[rd_idx];
                        result_next.entry_capacity  = capacity_reg[rd_idx];
                        result_next.entry_addr      = addr_reg[rd_idx];
                        result_next.entry_last_seen = seen_reg[rd_idx];
                    end
                    else
                        result_next.status = ST_BAD_INDEX;
                end
                OP_CLEAR:
                begin
                    valid_next = '0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        key_next[i]      = '0;
                        port_next[i]     = '0;
                        players_next[i]  = '0;
                        capacity_next[i] = '0;
                        addr_next[i]     = '0;
                        seen_next[i]     = '0;
                    end
                end
                default:
                begin
                    result_next.status = ST_DONE;
                end
            endcase
        end

        // span equals highest valid slot + 1, or zero when no slot is valid
        span_next  = '0;
        count_next = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (valid_next[i])
            begin
                span_next  = CNT_W'(i + 1);
                count_next = count_next + 1'b1;
            end
        end
        result_next.active_count = fit_cnt(count_next);
        result_next.span_used    = fit_cnt(span_next);
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_announcing_reg <= 1'b0;
            self_session_id_reg <= '0;
            magic_value_reg     <= '0;
            expiry_limit_ms_reg <= EXPIRY_RESET_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_ANNOUNCING: self_announcing_reg <= cfg_wdata[0];
                CFG_SELF_SESSION_ID: self_session_id_reg <= cfg_wdata;
                CFG_MAGIC_VALUE:     magic_value_reg     <= cfg_wdata;
                CFG_EXPIRY_LIMIT_MS: expiry_limit_ms_reg <= cfg_wdata;
                default:             self_announcing_reg <= self_announcing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                key_reg[i]      <= '0;
                port_reg[i]     <= '0;
                players_reg[i]  <= '0;
                capacity_reg[i] <= '0;
                addr_reg[i]     <= '0;
                seen_reg[i]     <= '0;
            end
        end
        else if (cmd.commit)
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                key_reg[i]      <= key_next[i];
                port_reg[i]     <= port_next[i];
                players_reg[i]  <= players_next[i];
                capacity_reg[i] <= capacity_next[i];
                addr_reg[i]     <= addr_next[i];
                seen_reg[i]     <= seen_next[i];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        if (cmd.lookup)
        begin
            lk_status_reg   <= lk_status_next;
            lk_slot_reg     <= lk_slot_next;
            expire_mask_reg <= expire_hit;
        end
        if (cmd.commit)
            result_reg <= result_next;
    end

endmodule

[design/peer_table_with_aging_unit.sv]
// Peer table with aging: top level, stream ports, config port, assertions.
// Sequencing: accept, LOOKUP registers the decision, COMMIT loads the result register.
// The next transaction is accepted in COMMIT, never in LOOKUP; a stalled result holds COMMIT.
// Reset (rst_n, async, active low): empty table, zero span, expiry limit 8000 ms.
// Depends on ptwa_pkg, ptwa_ctrl, ptwa_dp.
`timescale 1ns / 1ps
module peer_table_with_aging_unit
    import ptwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low to high: now_ms[31:0], packet_length[38:32],
    // announce_magic[70:39], announce_session[102:71], announce_port[118:103],
    // announce_players[126:119], announce_capacity[134:127],
    // sender_addr[166:135], entry_index[174:167], zero pad[175]
    input  logic [175:0]          s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]            s_axis_tuser,

    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low to high: slot_used[2:0], entry_active[3],
    // entry_session[35:4], entry_port[51:36], entry_players[59:52],
    // entry_capacity[67:60], entry_addr[99:68], entry_last_seen[131:100],
    // active_count[135:132], span_used[139:136], zero pad[143:140]
    output logic [143:0]          m_axis_tdata,
    // tuser: status[3:0]
    output logic [3:0]            m_axis_tuser,

    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    item_t   item_in;
    result_t result;

    // unpack the incoming transaction
    assign item_in.operation         = op_t'(s_axis_tuser);
    assign item_in.now_ms            = s_axis_tdata[31:0];
    assign item_in.packet_length     = s_axis_tdata[38:32];
    assign item_in.announce_magic    = s_axis_tdata[70:39];
    assign item_in.announce_session  = s_axis_tdata[102:71];
    assign item_in.announce_port     = s_axis_tdata[118:103];
    assign item_in.announce_players  = s_axis_tdata[126:119];
    assign item_in.announce_capacity = s_axis_tdata[134:127];
    assign item_in.sender_addr       = s_axis_tdata[166:135];
    assign item_in.entry_index       = s_axis_tdata[174:167];

    // Controller: IDLE accepts; LOOKUP registers match / free / oldest and
    // expire decisions; COMMIT writes the table and the result register.
    // COMMIT also accepts the next transaction, so back-to-back items overlap
    // one commit with the next acceptance; a stalled result holds COMMIT.
    ptwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    ptwa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item_in   (item_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // pack the result transaction
    assign m_axis_tuser = result.status;
    assign m_axis_tdata = {4'b0000,
                           result.span_used,
                           result.active_count,
                           result.entry_last_seen,
                           result.entry_addr,
                           result.entry_capacity,
                           result.entry_players,
                           result.entry_port,
                           result.entry_session,
                           result.entry_active,
                           result.slot_used};

    // ---------------- assertions ----------------

    // after acceptance the lookup cycle never takes a new transaction
    a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted during lookup");

    // active entries never exceed the used span
    a_count_le_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result.active_count <= result.span_used))
        else $error("active_count above span_used");

    // entry fields are zero unless the result is a successful read
    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (result.status != ST_READ_OK)) |->
        ((m_axis_tdata[131:3] == '0)))
        else $error("entry fields set on non-read result");

    // span stays within the table
    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result.span_used <= 4'(TABLE_ENTRIES)))
        else $error("span_used out of range");

endmodule
